### design/sem_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Sobel edge magnitude package
// Shared types and constants for the controller and the datapath.
// ----------------------------------------------------------------------------
package sem_pkg;

    localparam logic [0:0] REG_IMAGE_WIDTH  = 1'd0;
    localparam logic [0:0] REG_IMAGE_HEIGHT = 1'd1;

    localparam int CFG_WIDTH = 12;

    localparam logic [8:0]  GRAY_RED   = 9'd300;
    localparam logic [9:0]  GRAY_GREEN = 10'd590;
    localparam logic [6:0]  GRAY_BLUE  = 7'd110;
    // Exact reciprocal of 1000 for an 18-bit numerator: floor(x * M / 2^28).
    localparam logic [18:0] DIV_MAGIC  = 19'd268436;
    localparam int          DIV_SHIFT  = 28;

    localparam logic [11:0] WIDTH_RESET  = 12'd640;
    localparam logic [11:0] HEIGHT_RESET = 12'd480;
    localparam logic [11:0] DIM_MIN      = 12'd3;

    localparam logic [2:0] ROOT_LAST = 3'd7;

    typedef struct packed {
        logic       load;
        logic       gray_mul;
        logic       shift;
        logic       square;
        logic       root_step;
        logic [2:0] root_index;
        logic       out_load;
    } cmd_t;

    typedef struct packed {
        logic emit;
        logic out_full;
    } status_t;

endpackage
`default_nettype wire

### design/sem_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Sobel edge magnitude controller
// Sequences one pixel through gray conversion, window update and square root.
// ----------------------------------------------------------------------------
module sem_ctrl (
    input  wire logic            aclk,
    input  wire logic            aresetn,
    input  wire logic            in_valid,
    output logic                 in_ready,
    input  wire sem_pkg::status_t status,
    output sem_pkg::cmd_t        cmd
);

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_PROD  = 3'd1;
    localparam logic [2:0] ST_SHIFT = 3'd2;
    localparam logic [2:0] ST_SQ    = 3'd3;
    localparam logic [2:0] ST_ROOT  = 3'd4;
    localparam logic [2:0] ST_EMIT  = 3'd5;

    logic [2:0] state_reg, state_next;
    logic [2:0] step_reg, step_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            step_reg  <= 3'd0;
        end else begin
            state_reg <= state_next;
            step_reg  <= step_next;
        end
    end

    always_comb begin
        state_next     = state_reg;
        step_next      = step_reg;
        in_ready       = 1'b0;
        cmd            = '0;
        cmd.root_index = step_reg;
        case (state_reg)
            ST_IDLE: begin
                in_ready = 1'b1;
                if (in_valid) begin
                    cmd.load   = 1'b1;
                    state_next = ST_PROD;
                end
            end
            ST_PROD: begin
                cmd.gray_mul = 1'b1;
                state_next   = ST_SHIFT;
            end
            ST_SHIFT: begin
                cmd.shift  = 1'b1;
                state_next = ST_SQ;
            end
            ST_SQ: begin
                cmd.square = 1'b1;
                step_next  = 3'd0;
                state_next = ST_ROOT;
            end
            ST_ROOT: begin
                cmd.root_step = 1'b1;
                step_next     = step_reg + 3'd1;
                if (step_reg == sem_pkg::ROOT_LAST) begin
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT: begin
                if (!status.emit) begin
                    state_next = ST_IDLE;
                end else if (!status.out_full) begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule
`default_nettype wire

### design/sem_datapath.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Sobel edge magnitude datapath
// Counters, line stores, 3x3 window, gradient, square root and output register.
// ----------------------------------------------------------------------------
module sem_datapath #(
    parameter int MAX_WIDTH = 2048
) (
    input  wire logic                            aclk,
    input  wire logic                            aresetn,
    input  wire logic                            cfg_we,
    input  wire logic [0:0]                      cfg_addr,
    input  wire logic [sem_pkg::CFG_WIDTH-1:0]   cfg_wdata,
    input  wire logic [7:0]                      blue,
    input  wire logic [7:0]                      green,
    input  wire logic [7:0]                      red,
    input  wire sem_pkg::cmd_t                   cmd,
    output sem_pkg::status_t                     status,
    input  wire logic                            out_ready,
    output logic                                 out_valid,
    output logic [7:0]                           edge_value,
    output logic                                 frame_last
);

    localparam int AW  = $clog2(MAX_WIDTH);
    localparam int WCW = ($clog2(MAX_WIDTH + 1) > 12) ? $clog2(MAX_WIDTH + 1) : 12;
    localparam logic [WCW-1:0] MAXW = WCW'(MAX_WIDTH);

    logic [11:0]    width_reg, height_reg;
    logic [AW-1:0]  col_reg;
    logic [11:0]    row_reg;
    logic           started_reg;
    logic [AW-1:0]  c_reg;
    logic [11:0]    r_reg;
    logic           zero_col_reg, flast_reg;
    logic [17:0]    sum_reg;
    logic [36:0]    prod_reg;
    logic [7:0]     mem_prev  [MAX_WIDTH];
    logic [7:0]     mem_prev2 [MAX_WIDTH];
    logic [7:0]     rd_prev_reg, rd_prev2_reg;
    logic [7:0]     win_reg [3][3];
    logic [20:0]    ssum_reg;
    logic           sat_reg;
    logic [7:0]     root_reg;
    logic           out_valid_reg;
    logic [7:0]     out_edge_reg;
    logic           out_flast_reg;

    logic [WCW-1:0] w_eff, col_ext, cn;
    logic [11:0]    h_eff;
    logic [12:0]    r1, rn;
    logic [AW-1:0]  c_in;
    logic [11:0]    r_in;
    logic [7:0]     gray, top, mid, bot;
    logic signed [11:0] gx, gy;
    logic [7:0]     trial, bitm;
    logic [15:0]    trial_sq;

    always_comb begin
        w_eff = WCW'(width_reg);
        if (width_reg < sem_pkg::DIM_MIN) begin
            w_eff = WCW'(sem_pkg::DIM_MIN);
        end else if (WCW'(width_reg) > MAXW) begin
            w_eff = MAXW;
        end
        h_eff = (height_reg < sem_pkg::DIM_MIN) ? sem_pkg::DIM_MIN : height_reg;
        col_ext = WCW'(col_reg);
        if (col_ext >= w_eff) begin
            c_in = '0;
            r1   = {1'b0, row_reg} + 13'd1;
        end else begin
            c_in = col_reg;
            r1   = {1'b0, row_reg};
        end
        r_in = (r1 >= {1'b0, h_eff}) ? 12'd0 : r1[11:0];
        cn   = WCW'(c_in) + WCW'(1);
        rn   = {1'b0, r_in} + 13'd1;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            width_reg  <= sem_pkg::WIDTH_RESET;
            height_reg <= sem_pkg::HEIGHT_RESET;
        end else if (cfg_we) begin
            if (cfg_addr == sem_pkg::REG_IMAGE_WIDTH) begin
                width_reg <= cfg_wdata;
            end else begin
                height_reg <= cfg_wdata;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            col_reg     <= '0;
            row_reg     <= '0;
            started_reg <= 1'b0;
        end else if (cmd.load) begin
            if (r_in != 12'd0 && c_in != '0) begin
                started_reg <= 1'b1;
            end
            if (cn >= w_eff) begin
                col_reg <= '0;
                row_reg <= (rn >= {1'b0, h_eff}) ? 12'd0 : rn[11:0];
            end else begin
                col_reg <= cn[AW-1:0];
                row_reg <= r_in;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            c_reg        <= c_in;
            r_reg        <= r_in;
            zero_col_reg <= (c_in < AW'(2));
            flast_reg    <= (c_in == '0) && (r_in == 12'd1);
            sum_reg      <= 18'(red) * 18'(sem_pkg::GRAY_RED)
                          + 18'(green) * 18'(sem_pkg::GRAY_GREEN)
                          + 18'(blue) * 18'(sem_pkg::GRAY_BLUE);
            rd_prev_reg  <= mem_prev[c_in];
            rd_prev2_reg <= mem_prev2[c_in];
        end
        if (cmd.gray_mul) begin
            prod_reg <= 37'(sum_reg) * 37'(sem_pkg::DIV_MAGIC);
        end
    end

    always_comb begin
        gray = prod_reg[sem_pkg::DIV_SHIFT +: 8];
        mid  = rd_prev_reg;
        top  = (r_reg == 12'd1) ? mid : rd_prev2_reg;
        bot  = (r_reg == 12'd0) ? mid : gray;
    end

    always_ff @(posedge aclk) begin
        if (cmd.shift) begin
            mem_prev2[c_reg] <= rd_prev_reg;
            mem_prev[c_reg]  <= gray;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < 3; i++) begin
                for (int j = 0; j < 3; j++) begin
                    win_reg[i][j] <= '0;
                end
            end
        end else if (cmd.shift) begin
            for (int i = 0; i < 3; i++) begin
                win_reg[i][0] <= win_reg[i][1];
                win_reg[i][1] <= win_reg[i][2];
            end
            win_reg[0][2] <= top;
            win_reg[1][2] <= mid;
            win_reg[2][2] <= bot;
        end
    end

    always_comb begin
        gx = 12'(signed'({4'd0, win_reg[0][2]}) + signed'({3'd0, win_reg[1][2], 1'b0})
           + signed'({4'd0, win_reg[2][2]}) - signed'({4'd0, win_reg[0][0]})
           - signed'({3'd0, win_reg[1][0], 1'b0}) - signed'({4'd0, win_reg[2][0]}));
        gy = 12'(signed'({4'd0, win_reg[2][0]}) + signed'({3'd0, win_reg[2][1], 1'b0})
           + signed'({4'd0, win_reg[2][2]}) - signed'({4'd0, win_reg[0][0]})
           - signed'({3'd0, win_reg[0][1], 1'b0}) - signed'({4'd0, win_reg[0][2]}));
        bitm     = 8'h80 >> cmd.root_index;
        trial    = root_reg | bitm;
        trial_sq = 16'(trial) * 16'(trial);
    end

    always_ff @(posedge aclk) begin
        if (cmd.square) begin
            ssum_reg <= 21'(24'(gx) * 24'(gx) + 24'(gy) * 24'(gy));
            sat_reg  <= (24'(gx) * 24'(gx) + 24'(gy) * 24'(gy)) >= 24'sd65536;
            root_reg <= '0;
        end else if (cmd.root_step) begin
            if ({5'd0, trial_sq} <= ssum_reg) begin
                root_reg <= trial;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (cmd.out_load) begin
            out_valid_reg <= 1'b1;
        end else if (out_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.out_load) begin
            out_edge_reg  <= zero_col_reg ? 8'd0 : (sat_reg ? 8'd255 : root_reg);
            out_flast_reg <= flast_reg;
        end
    end

    assign status.emit     = started_reg;
    assign status.out_full = out_valid_reg;
    assign out_valid       = out_valid_reg;
    assign edge_value      = out_edge_reg;
    assign frame_last      = out_flast_reg;

endmodule
`default_nettype wire

### design/sobel_edge_magnitude.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Sobel edge magnitude
// Gray conversion, two line stores, 3x3 Sobel window and saturated magnitude.
// ----------------------------------------------------------------------------
// A pixel's result register is loaded after its transfer, once the gray
// multiply, the window update, the squaring and eight root steps are done.
// One pixel is in flight at a time: a new pixel is taken only after the last
// leaves the emit state, which stalls while the output register is full.
// Results appear width+1 pixels behind the input stream.
// Synchronous active-low reset clears counters and window and sets the configuration to 640 by 480.
module sobel_edge_magnitude #(
    parameter int MAX_WIDTH = 2048
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        cfg_we,
    input  wire logic [0:0]  cfg_addr,
    input  wire logic [11:0] cfg_wdata,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [23:0] s_tdata,   // blue, green, red
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [7:0]       m_tdata,   // edge_value
    output logic             m_tlast,
    output logic             m_tuser    // frame_last
);

    sem_pkg::cmd_t    cmd;
    sem_pkg::status_t status;

    sem_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (s_tvalid),
        .in_ready (s_tready),
        .status   (status),
        .cmd      (cmd)
    );

    sem_datapath #(
        .MAX_WIDTH (MAX_WIDTH)
    ) u_datapath (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg_we     (cfg_we),
        .cfg_addr   (cfg_addr),
        .cfg_wdata  (cfg_wdata),
        .blue       (s_tdata[7:0]),
        .green      (s_tdata[15:8]),
        .red        (s_tdata[23:16]),
        .cmd        (cmd),
        .status     (status),
        .out_ready  (m_tready),
        .out_valid  (m_tvalid),
        .edge_value (m_tdata),
        .frame_last (m_tuser)
    );

    assign m_tlast = 1'b1;

    a_one_in_flight: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("A second pixel was accepted while one was in progress.");

    a_frame_last_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser) |-> (m_tdata == 8'd0))
        else $error("The final pixel of an image carried a non-zero edge value.");

    a_load_waits: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.out_load |-> !m_tvalid)
        else $error("The result register was overwritten before its transfer.");

endmodule
`default_nettype wire
